>>> src/eqpr_pkg.sv
// ----------------------------------------------------------------------------
// eqpr_pkg: shared types, constants and elaboration helpers
// register codes, default sizes and the fixed-point trig series used to
// build the per-lane gain tables of the equal-power remap
// ----------------------------------------------------------------------------
`default_nettype none

package eqpr_pkg;

  localparam int DEF_MAX_IN      = 8;
  localparam int DEF_MAX_OUT     = 8;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_GAIN_BITS   = 16;

  // configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CH  = 2'd0,
    REG_OUT_CH = 2'd1
  } cfg_reg_t;

  // q2.30 constants of the gain series
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam int          TAYLOR_TERMS = 6;

  // restoring shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // taylor series for sin or cos of (r/d)*pi/2, clamped to [0, 1.0] in q2.30
  function automatic logic [30:0] trig_q30(input logic [63:0] r, input logic [63:0] d,
                                           input logic want_sin);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        k;
    logic signed [63:0] sum;
    a    = udiv(r * HALF_PI_Q30, d);
    a2   = (a * a) >> 30;
    term = want_sin ? a : Q30_ONE;
    k    = want_sin ? 64'd1 : 64'd0;
    sum  = $signed(term);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = udiv((term * a2) >> 30, (k + 64'd1) * (k + 64'd2));
      k    = k + 64'd2;
      if ((n % 2) == 1) sum = sum - $signed(term);
      else              sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    if (sum > $signed(Q30_ONE)) sum = $signed(Q30_ONE);
    return 31'(sum);
  endfunction

endpackage

`default_nettype wire

>>> src/eqpr_stream_if.sv
// ----------------------------------------------------------------------------
// eqpr_stream_if: valid/ready frame channel
// one word is a frame of CH samples, W bits each, two's complement
// ----------------------------------------------------------------------------
`default_nettype none

interface eqpr_stream_if #(
  parameter int CH = eqpr_pkg::DEF_MAX_IN,
  parameter int W  = eqpr_pkg::DEF_SAMPLE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [CH-1:0][W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> src/equal_power_channel_remap_top.sv
// ----------------------------------------------------------------------------
// equal_power_channel_remap_top: equal-power n-to-m channel remap
// first input to first output, last input to last output, each inner input
// panned between its two neighbor outputs with cos/sin gains
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake         | word
//   --------+-----+-------------------+---------------------------------------
//   in_s    | in  | valid/ready       | MAX_IN samples, signed q1.23
//   out_s   | out | valid/ready       | MAX_OUT samples, saturated q1.23
//   cfg_*   | in  | cfg_we, no wait   | cfg_idx selects in/out channel count
//
// one word per cycle while the output word is taken; from input to output
// a word passes capture, multiply, per-output partial sums, round, saturate
// pipeline advances as one; it holds whole when the output word is not taken,
// and in_s.ready follows that same advance
// gain map per lane is looked up from a constant table at every config write
// and is ready the next cycle; reset loads the 2-in/2-out map
//
`default_nettype none

module equal_power_channel_remap_top #(
  parameter int MAX_IN      = eqpr_pkg::DEF_MAX_IN,
  parameter int MAX_OUT     = eqpr_pkg::DEF_MAX_OUT,
  parameter int SAMPLE_BITS = eqpr_pkg::DEF_SAMPLE_BITS,
  parameter int GAIN_BITS   = eqpr_pkg::DEF_GAIN_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  eqpr_stream_if.sink                         in_s,
  eqpr_stream_if.source                       out_s,
  input  wire logic                           cfg_we,
  input  wire logic [eqpr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [eqpr_pkg::CFG_W-1:0]     cfg_wdata
);
  import eqpr_pkg::*;

  // ---------------------------------------------------------------- sizes
  localparam int NST       = 5;                          // pipeline stages
  localparam int FB        = GAIN_BITS - 1;              // gain fraction bits
  localparam int GS        = 30 - FB;                    // q30 to gain shift
  localparam int TGT_W     = $clog2(MAX_OUT);
  localparam int IN_IDX_W  = $clog2(MAX_IN);
  localparam int CNT_IN_W  = $clog2(MAX_IN + 1);
  localparam int CNT_OUT_W = $clog2(MAX_OUT + 1);
  localparam int ENT_W     = TGT_W + 2 * GAIN_BITS;
  localparam int TBL_N     = (MAX_IN + 1) * (MAX_OUT + 1);
  localparam int TIDX_W    = $clog2(TBL_N);
  localparam int PROD_W    = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int ACC_W     = PROD_W + $clog2(MAX_IN + 2) + 1;
  localparam int RND_W     = ACC_W - FB;

  localparam logic signed [RND_W-1:0] SAT_HI =
    RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

  typedef struct packed {
    logic [TGT_W-1:0]     tgt;    // lower output of the pair
    logic [GAIN_BITS-1:0] near_g; // cos gain to tgt
    logic [GAIN_BITS-1:0] far_g;  // sin gain to tgt+1
  } lane_map_t;

  // ------------------------------------------------- gain table build
  function automatic logic [GAIN_BITS-1:0] round_gain(input logic [30:0] s);
    logic [31:0] t;
    t = (32'(s) + (32'd1 << (GS - 1))) >> GS;
    return GAIN_BITS'(t);
  endfunction

  // entry (n, m) holds the map of one lane for n inputs and m outputs
  function automatic logic [TBL_N*ENT_W-1:0] build_lane_map(input int lane);
    logic [TBL_N*ENT_W-1:0] tbl;
    logic [63:0]            p;
    logic [63:0]            d;
    logic [63:0]            q;
    logic [63:0]            r;
    logic [GAIN_BITS-1:0]   gn;
    logic [GAIN_BITS-1:0]   gf;
    tbl = '0;
    for (int n = 2; n <= MAX_IN; n++) begin
      for (int m = 2; m <= MAX_OUT; m++) begin
        if (lane >= 1 && lane + 1 < n) begin
          p  = 64'(lane * (m - 1));
          d  = 64'(n - 1);
          q  = udiv(p, d);
          r  = p - q * d;
          gn = round_gain(trig_q30(r, d, 1'b0));
          gf = round_gain(trig_q30(r, d, 1'b1));
          if (q + 64'd1 < 64'(m)) begin
            tbl[(n * (MAX_OUT + 1) + m) * ENT_W +: ENT_W] = {TGT_W'(q), gn, gf};
          end
        end
      end
    end
    return tbl;
  endfunction

  // ------------------------------------------------- configuration
  logic [CNT_IN_W-1:0]  n_r, n_nxt;
  logic [CNT_OUT_W-1:0] m_r, m_nxt;
  logic [TIDX_W-1:0]    tidx;
  lane_map_t            map_r   [MAX_IN];
  lane_map_t            map_nxt [MAX_IN];

  // counts below 2 act as 2, above the maximum as the maximum
  always_comb begin
    n_nxt = n_r;
    m_nxt = m_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_IN_CH: begin
          if (cfg_wdata < CFG_W'(2))           n_nxt = CNT_IN_W'(2);
          else if (cfg_wdata > CFG_W'(MAX_IN)) n_nxt = CNT_IN_W'(MAX_IN);
          else                                 n_nxt = CNT_IN_W'(cfg_wdata);
        end
        REG_OUT_CH: begin
          if (cfg_wdata < CFG_W'(2))            m_nxt = CNT_OUT_W'(2);
          else if (cfg_wdata > CFG_W'(MAX_OUT)) m_nxt = CNT_OUT_W'(MAX_OUT);
          else                                  m_nxt = CNT_OUT_W'(cfg_wdata);
        end
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  assign tidx = TIDX_W'(n_nxt) * TIDX_W'(MAX_OUT + 1) + TIDX_W'(m_nxt);

  for (genvar g = 0; g < MAX_IN; g++) begin : g_lane_map
    localparam logic [TBL_N*ENT_W-1:0] MAP_TBL = build_lane_map(g);
    assign map_nxt[g] = lane_map_t'(MAP_TBL[tidx * ENT_W +: ENT_W]);
  end

  // 2-in/2-out has no inner lanes, so the reset map is all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= CNT_IN_W'(2);
      m_r <= CNT_OUT_W'(2);
      for (int i = 0; i < MAX_IN; i++) map_r[i] <= '0;
    end else begin
      n_r <= n_nxt;
      m_r <= m_nxt;
      for (int i = 0; i < MAX_IN; i++) map_r[i] <= map_nxt[i];
    end
  end

  // ------------------------------------------------- pipeline control
  logic [NST-1:0] v_r, v_nxt;
  logic           adv;
  logic           in_fire;

  assign adv        = !v_r[NST-1] || out_s.ready;
  assign in_s.ready = adv;
  assign in_fire    = in_s.valid && adv;
  assign v_nxt      = adv ? {v_r[NST-2:0], in_s.valid} : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  // ------------------------------------------------- stage 1: capture
  logic signed [SAMPLE_BITS-1:0] smp1_r [MAX_IN];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_IN; i++) smp1_r[i] <= $signed(in_s.sample[i]);
    end
  end

  // ------------------------------------------------- stage 2: multiply
  logic signed [PROD_W-1:0]      pn2_r [MAX_IN];
  logic signed [PROD_W-1:0]      pf2_r [MAX_IN];
  logic signed [SAMPLE_BITS-1:0] e0_2_r;
  logic signed [SAMPLE_BITS-1:0] el_2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_IN; i++) begin
        pn2_r[i] <= smp1_r[i] * $signed({1'b0, map_r[i].near_g});
        pf2_r[i] <= smp1_r[i] * $signed({1'b0, map_r[i].far_g});
      end
      e0_2_r <= smp1_r[0];
      el_2_r <= smp1_r[IN_IDX_W'(n_r - CNT_IN_W'(1))];
    end
  end

  // ------------------------------------------------- stage 3: partial sums
  // near sum gathers cos terms landing on this output plus the first edge,
  // far sum the sin terms from the pair below plus the last edge
  logic signed [ACC_W-1:0] nsum3_r [MAX_OUT];
  logic signed [ACC_W-1:0] fsum3_r [MAX_OUT];
  logic signed [ACC_W-1:0] nsum3_nxt [MAX_OUT];
  logic signed [ACC_W-1:0] fsum3_nxt [MAX_OUT];

  always_comb begin
    for (int o = 0; o < MAX_OUT; o++) begin
      nsum3_nxt[o] = '0;
      fsum3_nxt[o] = '0;
      if (o == 0) nsum3_nxt[o] = ACC_W'(e0_2_r) <<< FB;
      if (m_r - CNT_OUT_W'(1) == CNT_OUT_W'(o)) fsum3_nxt[o] = ACC_W'(el_2_r) <<< FB;
      for (int i = 0; i < MAX_IN; i++) begin
        if (map_r[i].tgt == TGT_W'(o)) begin
          nsum3_nxt[o] = nsum3_nxt[o] + ACC_W'(pn2_r[i]);
        end
        if ({1'b0, map_r[i].tgt} + (TGT_W + 1)'(1) == (TGT_W + 1)'(o)) begin
          fsum3_nxt[o] = fsum3_nxt[o] + ACC_W'(pf2_r[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int o = 0; o < MAX_OUT; o++) begin
        nsum3_r[o] <= nsum3_nxt[o];
        fsum3_r[o] <= fsum3_nxt[o];
      end
    end
  end

  // ------------------------------------------------- stage 4: round
  // round half up, then arithmetic shift drops the gain fraction
  logic signed [RND_W-1:0] rnd4_r [MAX_OUT];
  logic signed [ACC_W-1:0] tot4   [MAX_OUT];

  always_comb begin
    for (int o = 0; o < MAX_OUT; o++) begin
      tot4[o] = nsum3_r[o] + fsum3_r[o] + (ACC_W'(1) <<< (FB - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int o = 0; o < MAX_OUT; o++) rnd4_r[o] <= RND_W'(tot4[o] >>> FB);
    end
  end

  // ------------------------------------------------- stage 5: saturate
  logic [SAMPLE_BITS-1:0] out5_r [MAX_OUT];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int o = 0; o < MAX_OUT; o++) begin
        if (CNT_OUT_W'(o) >= m_r)   out5_r[o] <= '0;
        else if (rnd4_r[o] > SAT_HI) out5_r[o] <= SAMPLE_BITS'(SAT_HI);
        else if (rnd4_r[o] < SAT_LO) out5_r[o] <= SAMPLE_BITS'(SAT_LO);
        else                         out5_r[o] <= SAMPLE_BITS'(rnd4_r[o]);
      end
    end
  end

  assign out_s.valid = v_r[NST-1];
  for (genvar g = 0; g < MAX_OUT; g++) begin : g_out
    assign out_s.sample[g] = out5_r[g];
  end

  // ------------------------------------------------- assertions
  // an accepted word always lands in the capture stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v_r[0])
    else $error("accepted word missing from capture stage");

  // a held pipeline keeps every valid bit in place
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline valids moved during stall");

  // lane 0 is an edge channel and never carries pan gains
  a_edge_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    map_r[0].near_g == '0 && map_r[0].far_g == '0)
    else $error("edge lane has pan gain");

endmodule

`default_nettype wire
